@@ src/lpht_pkg.sv @@
// Shared types, codes and default sizes for the linear probing hash table.
package lpht_pkg;

    // Default sizes for the top level parameters.
    localparam int SLOTS_DEF        = 16;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 64;

    // Command codes carried by a request.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_UPDATE = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    // Per slot tag.
    typedef enum logic [1:0] {
        TAG_FREE = 2'd0,
        TAG_DEAD = 2'd1,
        TAG_USED = 2'd2
    } tag_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } state_t;

    // Request payload.
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] key;
        logic [63:0] payload;
    } req_t;

    // Response payload.
    typedef struct packed {
        status_t     status;
        logic [3:0]  slot;
        logic [63:0] data_out;
    } rsp_t;

endpackage

@@ src/linear_probe_hash_table.sv @@
// Open addressing hash table with linear probing, one slot examined per cycle.
//
// Usage: requests (insert, search, delete, update) arrive on the req channel
// and each produces exactly one response on the rsp channel, both valid/ready.
// The block takes one request at a time; req_ready is high only while idle.
// The home slot is key mod SLOTS. For a power of two SLOTS it is a bit
// select; otherwise a single compare/subtract unit reduces the key one
// bit per cycle. Probing reads the tag, key and payload memories once
// per cycle through registered read ports and checks each probed slot
// from those read registers. The result is held in an output register.
// The block goes back to idle as the response is loaded and is ready for
// the next request in the following cycle. If the receiver stalls with a
// response still waiting, a finished request holds its memory update until
// that response transfers.
// Reset: a clearing pass marks every slot never used, one slot per cycle,
// after reset is released; req_ready stays low until it ends.
module linear_probe_hash_table #(
    parameter int SLOTS        = lpht_pkg::SLOTS_DEF,
    parameter int KEY_BITS     = lpht_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = lpht_pkg::PAYLOAD_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  lpht_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output lpht_pkg::rsp_t  rsp
);

    localparam int  SLOT_W  = $clog2(SLOTS);
    localparam int  BIT_W   = $clog2(KEY_BITS);
    localparam int  HW      = (KEY_BITS > SLOT_W) ? KEY_BITS : SLOT_W;
    localparam bit  IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W + 1)'(SLOTS);

    // Control registers.
    lpht_pkg::state_t     state_reg, state_next;
    logic [SLOT_W-1:0]    clr_idx_reg, clr_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0]    chk_cnt_reg, chk_cnt_next;

    // Datapath registers.
    lpht_pkg::cmd_t       cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [SLOT_W-1:0]    rem_reg, rem_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [SLOT_W-1:0]    chk_idx_reg, chk_idx_next;
    lpht_pkg::status_t    res_status_reg, res_status_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [PAYLOAD_BITS-1:0] res_data_reg, res_data_next;
    lpht_pkg::rsp_t       rsp_reg, rsp_next;

    // Memories and their ports.
    lpht_pkg::tag_t          tag_mem [SLOTS];
    logic [KEY_BITS-1:0]     key_mem [SLOTS];
    logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];
    lpht_pkg::tag_t          tag_rd_reg;
    logic [KEY_BITS-1:0]     key_rd_reg;
    logic [PAYLOAD_BITS-1:0] pay_rd_reg;
    logic                    tag_we, key_we, pay_we;
    logic [SLOT_W-1:0]       wr_addr;
    lpht_pkg::tag_t          tag_wdata;

    // Combinational helpers.
    logic [KEY_BITS-1:0]     key_in;
    logic [HW-1:0]           key_hw;
    logic [SLOT_W:0]         rem_trial;
    logic                    last_probe;
    logic                    hit;
    logic                    miss;

    assign key_in = KEY_BITS'(req.key);
    assign key_hw = HW'(key_in);

    // Memories: one write port, one registered read port at the probe index.
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[wr_addr] <= tag_wdata;
        end
        tag_rd_reg <= tag_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        key_rd_reg <= key_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[wr_addr] <= pay_reg;
        end
        pay_rd_reg <= pay_mem[idx_reg];
    end

    // Control state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpht_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            chk_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            chk_valid_reg <= chk_valid_next;
            chk_cnt_reg   <= chk_cnt_next;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        rem_reg        <= rem_next;
        bit_reg        <= bit_next;
        idx_reg        <= idx_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_data_reg   <= res_data_next;
        rsp_reg        <= rsp_next;
    end

    // Sequencer: next state, probe decisions and memory writes.
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        chk_valid_next  = chk_valid_reg;
        chk_cnt_next    = chk_cnt_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        idx_next        = idx_reg;
        chk_idx_next    = chk_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_data_next   = res_data_reg;
        rsp_next        = rsp_reg;
        req_ready       = 1'b0;
        tag_we          = 1'b0;
        key_we          = 1'b0;
        pay_we          = 1'b0;
        wr_addr         = res_slot_reg;
        tag_wdata       = lpht_pkg::TAG_USED;
        rem_trial       = {rem_reg, key_reg[bit_reg]};
        last_probe      = (chk_cnt_reg == LAST_SLOT);
        hit             = 1'b0;
        miss            = 1'b0;

        unique case (state_reg)
            lpht_pkg::ST_CLEAR:
            begin
                // Mark one slot never used per cycle.
                tag_we       = 1'b1;
                wr_addr      = clr_idx_reg;
                tag_wdata    = lpht_pkg::TAG_FREE;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_SLOT)
                begin
                    state_next = lpht_pkg::ST_IDLE;
                end
            end

            lpht_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next       = req.cmd;
                    key_next       = key_in;
                    pay_next       = PAYLOAD_BITS'(req.payload);
                    chk_valid_next = 1'b0;
                    chk_cnt_next   = '0;
                    rem_next       = '0;
                    bit_next       = BIT_W'(KEY_BITS - 1);
                    if (IS_POW2)
                    begin
                        idx_next   = key_hw[SLOT_W-1:0];
                        state_next = lpht_pkg::ST_PROBE;
                    end
                    else
                    begin
                        state_next = lpht_pkg::ST_HASH;
                    end
                end
            end

            lpht_pkg::ST_HASH:
            begin
                // Restoring remainder step, most significant key bit first.
                if (rem_trial >= SLOTS_EXT)
                begin
                    rem_trial = rem_trial - SLOTS_EXT;
                end
                rem_next = rem_trial[SLOT_W-1:0];
                if (bit_reg == '0)
                begin
                    idx_next   = rem_trial[SLOT_W-1:0];
                    state_next = lpht_pkg::ST_PROBE;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end

            lpht_pkg::ST_PROBE:
            begin
                // Issue the next read while checking the slot read last cycle.
                idx_next       = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
                chk_idx_next   = idx_reg;
                chk_valid_next = 1'b1;
                if (chk_valid_reg)
                begin
                    chk_cnt_next = chk_cnt_reg + 1'b1;
                    if (cmd_reg == lpht_pkg::CMD_INSERT)
                    begin
                        hit  = (tag_rd_reg == lpht_pkg::TAG_FREE)
                            || (tag_rd_reg == lpht_pkg::TAG_DEAD);
                        miss = !hit && last_probe;
                    end
                    else
                    begin
                        hit  = (tag_rd_reg == lpht_pkg::TAG_USED)
                            && (key_rd_reg == key_reg);
                        miss = !hit && ((tag_rd_reg == lpht_pkg::TAG_FREE) || last_probe);
                    end
                    if (hit)
                    begin
                        res_status_next = lpht_pkg::STAT_OK;
                        res_slot_next   = chk_idx_reg;
                        res_data_next   = (cmd_reg == lpht_pkg::CMD_SEARCH) ? pay_rd_reg : '0;
                        state_next      = lpht_pkg::ST_DONE;
                    end
                    else if (miss)
                    begin
                        res_status_next = (cmd_reg == lpht_pkg::CMD_INSERT)
                            ? lpht_pkg::STAT_FULL : lpht_pkg::STAT_NOTFOUND;
                        res_slot_next   = '0;
                        res_data_next   = '0;
                        state_next      = lpht_pkg::ST_DONE;
                    end
                end
            end

            lpht_pkg::ST_DONE:
            begin
                // Commit the update together with loading the response.
                if (!out_valid_reg || rsp_ready)
                begin
                    if (res_status_reg == lpht_pkg::STAT_OK)
                    begin
                        unique case (cmd_reg)
                            lpht_pkg::CMD_INSERT:
                            begin
                                tag_we    = 1'b1;
                                key_we    = 1'b1;
                                pay_we    = 1'b1;
                                tag_wdata = lpht_pkg::TAG_USED;
                            end
                            lpht_pkg::CMD_DELETE:
                            begin
                                tag_we    = 1'b1;
                                tag_wdata = lpht_pkg::TAG_DEAD;
                            end
                            lpht_pkg::CMD_UPDATE:
                            begin
                                pay_we = 1'b1;
                            end
                            lpht_pkg::CMD_SEARCH:
                            begin
                                tag_we = 1'b0;
                            end
                        endcase
                    end
                    rsp_next.status   = res_status_reg;
                    rsp_next.slot     = 4'(res_slot_reg);
                    rsp_next.data_out = 64'(res_data_reg);
                    out_valid_next    = 1'b1;
                    state_next        = lpht_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // A failed request reports slot zero and no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != lpht_pkg::STAT_OK))
            |-> ((rsp.slot == 4'd0) && (rsp.data_out == 64'd0)))
    else $error("failed response carries a slot or data");

    // A new response is loaded only from the commit state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == lpht_pkg::ST_DONE))
    else $error("response appeared outside the commit state");

    // No request is taken while the clearing pass runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpht_pkg::ST_CLEAR) |-> !req_ready)
    else $error("request accepted during clearing pass");
`endif

endmodule
